### src/byte_ring_fifo_overwrite_find_macros.svh
// Assertion macros used by the checker file of the byte ring FIFO.
`ifndef BYTE_RING_FIFO_OVERWRITE_FIND_MACROS_SVH
`define BYTE_RING_FIFO_OVERWRITE_FIND_MACROS_SVH

// Clocked property with reset disable; prop must not carry top-level commas.
`define BRF_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Implication checked on the same edge.
`define BRF_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  `BRF_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

// Implication checked on the next edge.
`define BRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  `BRF_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

### src/brf_pkg.sv
// Package: constants, codes and shared types of the byte ring FIFO.
package brf_pkg;

  localparam int CAPACITY = 255;
  localparam int SLOTS    = CAPACITY + 1;
  localparam int PTR_W    = $clog2(SLOTS);
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 7;
  localparam int MAX_RUN  = 64;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_FIND  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REFUSED   = 2'd1,
    ST_OVERWRITE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_RD,
    S_POP_EM,
    S_FIND_RD,
    S_FIND_CMP,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic  we;
    ptr_t  waddr;
    byte_t wdata;
    logic  re;
    ptr_t  raddr;
  } mem_req_t;

endpackage

### src/brf_store.sv
// Byte store: one write port, one read port with registered read data.
module brf_store (
  input  logic              clk,
  input  brf_pkg::mem_req_t mem_req,
  output brf_pkg::byte_t    rd_data
);

  brf_pkg::byte_t mem [brf_pkg::SLOTS];
  brf_pkg::byte_t rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    // hold read data until the next read request
    if (mem_req.re) begin
      rd_data_r <= mem[mem_req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/brf_ctrl.sv
// Sequencer: pointers, shared compare step, result register.
module brf_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_opcode,
  input  brf_pkg::byte_t           in_data_byte,
  input  logic [brf_pkg::CNT_W-1:0] in_pop_count,
  input  brf_pkg::byte_t           in_search_offset,
  output logic                     out_valid,
  input  logic                     out_stall,
  output brf_pkg::byte_t           out_out_byte,
  output brf_pkg::byte_t           out_found_position,
  output brf_pkg::byte_t           out_fill_count,
  output logic [1:0]               out_status,
  output logic                     out_last_of_run,
  output brf_pkg::mem_req_t        mem_req,
  input  brf_pkg::byte_t           rd_data
);

  brf_pkg::state_t state_r, state_nxt;
  brf_pkg::ptr_t   wp_r, wp_nxt, rp_r, rp_nxt;
  brf_pkg::op_t    op_r, op_nxt;
  brf_pkg::byte_t  key_r, key_nxt;
  logic [brf_pkg::CNT_W-1:0] cnt_r, cnt_nxt, rem_r, rem_nxt;
  brf_pkg::byte_t  off_r, off_nxt;
  brf_pkg::ptr_t   idx_r, idx_nxt;
  brf_pkg::byte_t  res_pos_r, res_pos_nxt, res_fill_r, res_fill_nxt;
  brf_pkg::status_t res_status_r, res_status_nxt;
  logic            out_valid_r, out_valid_nxt;
  brf_pkg::byte_t  out_byte_r, out_byte_nxt, out_pos_r, out_pos_nxt;
  brf_pkg::byte_t  out_fill_r, out_fill_nxt;
  brf_pkg::status_t out_status_r, out_status_nxt;
  logic            out_last_r, out_last_nxt;

  brf_pkg::ptr_t   used;
  logic            accept;
  logic            out_free;
  logic            refused;
  logic            full;
  logic            match;
  logic            scan_end;

  assign used     = wp_r - rp_r;
  assign accept   = in_valid && (state_r == brf_pkg::S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign refused  = ({1'b0, cnt_r} > used) ||
                    (cnt_r > brf_pkg::CNT_W'(brf_pkg::MAX_RUN));
  assign full     = (used == brf_pkg::PTR_W'(brf_pkg::CAPACITY));
  assign match    = (rd_data == key_r);
  assign scan_end = ((idx_r + 1'b1) == used);

  assign in_stall           = (state_r != brf_pkg::S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_out_byte       = out_byte_r;
  assign out_found_position = out_pos_r;
  assign out_fill_count     = out_fill_r;
  assign out_status         = out_status_r;
  assign out_last_of_run    = out_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      brf_pkg::S_IDLE: begin
        if (accept) state_nxt = brf_pkg::S_EXEC;
      end
      brf_pkg::S_EXEC: begin
        unique case (op_r)
          brf_pkg::OP_POP: begin
            if (refused || (cnt_r == '0)) state_nxt = brf_pkg::S_EMIT;
            else state_nxt = brf_pkg::S_POP_RD;
          end
          brf_pkg::OP_FIND: begin
            if (off_r >= used) state_nxt = brf_pkg::S_EMIT;
            else state_nxt = brf_pkg::S_FIND_RD;
          end
          default: state_nxt = brf_pkg::S_EMIT;
        endcase
      end
      brf_pkg::S_POP_RD: state_nxt = brf_pkg::S_POP_EM;
      brf_pkg::S_POP_EM: begin
        if (out_free) begin
          state_nxt = (rem_r == brf_pkg::CNT_W'(1)) ? brf_pkg::S_IDLE : brf_pkg::S_POP_RD;
        end
      end
      brf_pkg::S_FIND_RD: state_nxt = brf_pkg::S_FIND_CMP;
      brf_pkg::S_FIND_CMP: begin
        if (match || scan_end) state_nxt = brf_pkg::S_EMIT;
        else state_nxt = brf_pkg::S_FIND_RD;
      end
      brf_pkg::S_EMIT: begin
        if (out_free) state_nxt = brf_pkg::S_IDLE;
      end
      default: state_nxt = brf_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    wp_nxt         = wp_r;
    rp_nxt         = rp_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    cnt_nxt        = cnt_r;
    off_nxt        = off_r;
    rem_nxt        = rem_r;
    idx_nxt        = idx_r;
    res_pos_nxt    = res_pos_r;
    res_fill_nxt   = res_fill_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_byte_nxt   = out_byte_r;
    out_pos_nxt    = out_pos_r;
    out_fill_nxt   = out_fill_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    mem_req        = '0;

    unique case (state_r)
      brf_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt  = brf_pkg::op_t'(in_opcode);
          key_nxt = in_data_byte;
          cnt_nxt = in_pop_count;
          off_nxt = in_search_offset;
        end
      end
      brf_pkg::S_EXEC: begin
        res_pos_nxt    = '0;
        res_fill_nxt   = used;
        res_status_nxt = brf_pkg::ST_OK;
        unique case (op_r)
          brf_pkg::OP_PUSH: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = wp_r;
            mem_req.wdata = key_r;
            wp_nxt        = wp_r + 1'b1;
            if (full) begin
              // drop the oldest byte: read pointer lands one past new write pointer
              rp_nxt         = wp_r + brf_pkg::PTR_W'(2);
              res_status_nxt = brf_pkg::ST_OVERWRITE;
            end else begin
              res_fill_nxt = used + 1'b1;
            end
          end
          brf_pkg::OP_POP: begin
            if (refused) begin
              res_status_nxt = brf_pkg::ST_REFUSED;
            end else begin
              rem_nxt      = cnt_r;
              res_fill_nxt = used - {1'b0, cnt_r};
            end
          end
          brf_pkg::OP_FIND: begin
            if (off_r >= used) res_pos_nxt = used;
            else idx_nxt = off_r;
          end
          brf_pkg::OP_CLEAR: begin
            wp_nxt       = '0;
            rp_nxt       = '0;
            res_fill_nxt = '0;
          end
          default: ;
        endcase
      end
      brf_pkg::S_POP_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = rp_r;
        rp_nxt        = rp_r + 1'b1;
      end
      brf_pkg::S_POP_EM: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = rd_data;
          out_pos_nxt    = '0;
          out_fill_nxt   = res_fill_r;
          out_status_nxt = brf_pkg::ST_OK;
          out_last_nxt   = (rem_r == brf_pkg::CNT_W'(1));
          rem_nxt        = rem_r - 1'b1;
        end
      end
      brf_pkg::S_FIND_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = rp_r + idx_r;
      end
      brf_pkg::S_FIND_CMP: begin
        if (match) res_pos_nxt = idx_r;
        else if (scan_end) res_pos_nxt = used;
        else idx_nxt = idx_r + 1'b1;
      end
      brf_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = '0;
          out_pos_nxt    = res_pos_r;
          out_fill_nxt   = res_fill_r;
          out_status_nxt = res_status_r;
          out_last_nxt   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brf_pkg::S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    cnt_r        <= cnt_nxt;
    off_r        <= off_nxt;
    rem_r        <= rem_nxt;
    idx_r        <= idx_nxt;
    res_pos_r    <= res_pos_nxt;
    res_fill_r   <= res_fill_nxt;
    res_status_r <= res_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_pos_r    <= out_pos_nxt;
    out_fill_r   <= out_fill_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

### src/byte_ring_fifo_overwrite_find.sv
// Top level: circular byte FIFO with overwrite on full, run pop and byte find.
//
//   channel | handshake          | payload
//   --------+--------------------+-----------------------------------------------
//   in_     | in_valid/in_stall  | opcode, data_byte, pop_count, search_offset
//   out_    | out_valid/out_stall| out_byte, found_position, fill_count,
//           |                    | status, last_of_run
//
// Sequence: push, clear, a refused pop and a pop of zero bytes go from accept
//   through the execute and emit states to the result; a pop of N bytes runs a
//   read and an emit state per byte, a find a read and a compare state per byte
//   scanned, then the emit state. The single memory read port with registered
//   read data and the one shared byte comparator handle one byte at a time.
// Reset: rst_n low clears state and both pointers; store contents stay unknown.
// Stalls: in_stall is high from accept until the last item of the run has
//   been loaded into the output register; out_stall holds that register.
module byte_ring_fifo_overwrite_find (
  input  logic                      clk,
  input  logic                      rst_n,
  // request channel
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_opcode,
  input  brf_pkg::byte_t            in_data_byte,
  input  logic [brf_pkg::CNT_W-1:0] in_pop_count,
  input  brf_pkg::byte_t            in_search_offset,
  // result channel
  output logic                      out_valid,
  input  logic                      out_stall,
  output brf_pkg::byte_t            out_out_byte,
  output brf_pkg::byte_t            out_found_position,
  output brf_pkg::byte_t            out_fill_count,
  output logic [1:0]                out_status,
  output logic                      out_last_of_run
);

  // request from the sequencer to the store, and data coming back
  brf_pkg::mem_req_t mem_req;
  brf_pkg::byte_t    rd_data;

  // Sequencer: decodes the item, walks the store one byte per step and
  // feeds the output register. Pointers live here; the fill count is the
  // pointer difference modulo the slot count, one slot kept free.
  brf_ctrl u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_data_byte       (in_data_byte),
    .in_pop_count       (in_pop_count),
    .in_search_offset   (in_search_offset),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_out_byte       (out_out_byte),
    .out_found_position (out_found_position),
    .out_fill_count     (out_fill_count),
    .out_status         (out_status),
    .out_last_of_run    (out_last_of_run),
    .mem_req            (mem_req),
    .rd_data            (rd_data)
  );

  // Storage: one slot per pointer value; only entries between the pointers
  // are ever read, and those were all written by a push.
  brf_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

endmodule

### src/brf_chk.sv
// Port checker for the byte ring FIFO, bound to the top level.
`include "byte_ring_fifo_overwrite_find_macros.svh"

module brf_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [brf_pkg::BYTE_W-1:0] out_out_byte,
  input logic [brf_pkg::BYTE_W-1:0] out_fill_count,
  input logic [1:0]                 out_status,
  input logic                       out_last_of_run
);

  // one item at a time: an accepted request closes the input side
  `BRF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
    in_valid && !in_stall, in_stall, "input not held off after accept")

  // a refused pop is a single flagged result with no data
  `BRF_ASSERT_IMP(a_refused_single, clk, rst_n,
    out_valid && (out_status == brf_pkg::ST_REFUSED),
    out_last_of_run && (out_out_byte == '0), "refused pop result malformed")

  // an overwriting push leaves the FIFO full
  `BRF_ASSERT_IMP(a_overwrite_full, clk, rst_n,
    out_valid && (out_status == brf_pkg::ST_OVERWRITE),
    out_last_of_run && (out_fill_count == brf_pkg::BYTE_W'(brf_pkg::CAPACITY)),
    "overwrite without full FIFO")

  // a stalled result holds its data
  `BRF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_out_byte) && $stable(out_last_of_run), "stalled result changed")

endmodule

bind byte_ring_fifo_overwrite_find brf_chk u_brf_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_out_byte    (out_out_byte),
  .out_fill_count  (out_fill_count),
  .out_status      (out_status),
  .out_last_of_run (out_last_of_run)
);
